>>> design/asn_pkg.sv
package asn_pkg;

  // fixed-point scale: 2^FRAC_BITS stands for 1.0
  localparam int FRAC_BITS = 31;
  // widest significand: float64 with hidden bit
  localparam int MANT_W    = 53;
  // shift window: significand followed by FRAC_BITS zero bits
  localparam int WIN_W     = MANT_W + FRAC_BITS;
  // right-shift amount, saturating; anything past the window gives zero
  localparam int RS_W      = $clog2(WIN_W + 1);
  localparam int VALUE_W   = 33;
  localparam int EXP_W     = 13;

  typedef enum logic [1:0] {
    ENC_PCM_BE  = 2'd0,
    ENC_PCM_LE  = 2'd1,
    ENC_FLOAT32 = 2'd2,
    ENC_FLOAT64 = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_NAN         = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic CFG_ENCODING    = 1'b0;
  localparam logic CFG_SAMPLE_BITS = 1'b1;

  localparam enc_t       ENCODING_RESET    = ENC_PCM_BE;
  localparam logic [6:0] SAMPLE_BITS_RESET = 7'd16;

  // exponent bias plus fraction width
  localparam logic signed [EXP_W-1:0] F32_BIAS = 13'sd150;
  localparam logic signed [EXP_W-1:0] F64_BIAS = 13'sd1075;

  typedef struct packed {
    logic    valid;
    logic    neg;
    logic    sat;
    logic    zero;
    status_t status;
  } ctl_t;

endpackage

>>> design/asn_decode.sv
module asn_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [63:0]                   sample_bytes,
  input  asn_pkg::enc_t                 encoding,
  input  logic [6:0]                    sample_bits,
  output asn_pkg::ctl_t                 ctl,
  output logic [asn_pkg::MANT_W-1:0]    mant,
  output logic [asn_pkg::RS_W-1:0]      rshift
);

  localparam logic signed [asn_pkg::EXP_W-1:0] RS_MAX =
    asn_pkg::EXP_W'((1 << asn_pkg::RS_W) - 1);

  logic [7:0]                          b [8];
  logic                                is_int;
  logic                                is_f32;
  logic                                is_f64;
  logic signed [32:0]                  ival;
  logic [32:0]                         imag;
  logic [31:0]                         f32;
  logic [63:0]                         f64;
  logic                                fexp_max;
  logic                                fexp_zero;
  logic                                frac_nz;
  logic signed [asn_pkg::EXP_W-1:0]    rs_full;
  asn_pkg::ctl_t                       ctl_next;
  logic [asn_pkg::MANT_W-1:0]          mant_next;
  logic [asn_pkg::RS_W-1:0]            rshift_next;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = sample_bytes[8*k +: 8];
    end
  end

  always_comb begin
    is_int    = 1'b0;
    is_f32    = 1'b0;
    is_f64    = 1'b0;
    ival      = '0;
    rs_full   = '0;
    ctl_next  = '0;
    mant_next = '0;
    ctl_next.valid  = start;
    ctl_next.status = asn_pkg::ST_OK;

    unique case (encoding)
      asn_pkg::ENC_PCM_BE: begin
        case (sample_bits)
          7'd8: begin
            is_int  = 1'b1;
            ival    = {{25{b[0][7]}}, b[0]};
            rs_full = 13'sd7;
          end
          7'd16: begin
            is_int  = 1'b1;
            ival    = {{17{b[0][7]}}, b[0], b[1]};
            rs_full = 13'sd15;
          end
          7'd24: begin
            is_int  = 1'b1;
            ival    = {{9{b[0][7]}}, b[0], b[1], b[2]};
            rs_full = 13'sd23;
          end
          7'd32: begin
            is_int  = 1'b1;
            ival    = {b[0][7], b[0], b[1], b[2], b[3]};
            rs_full = 13'sd31;
          end
          default: is_int = 1'b0;
        endcase
      end
      asn_pkg::ENC_PCM_LE: begin
        if (sample_bits == 7'd16) begin
          is_int  = 1'b1;
          ival    = {{17{b[1][7]}}, b[1], b[0]};
          rs_full = 13'sd15;
        end
      end
      asn_pkg::ENC_FLOAT32: is_f32 = (sample_bits == 7'd32);
      asn_pkg::ENC_FLOAT64: is_f64 = (sample_bits == 7'd64);
      default: is_int = 1'b0;
    endcase

    // float fields, first file byte most significant
    f32 = {b[0], b[1], b[2], b[3]};
    f64 = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};

    // pcm magnitude; the most negative code stays exact in 33 bits
    imag = ival[32] ? 33'(-ival) : 33'(ival);

    fexp_max  = 1'b0;
    fexp_zero = 1'b0;
    frac_nz   = 1'b0;

    if (is_int) begin
      ctl_next.neg = ival[32];
      mant_next    = asn_pkg::MANT_W'(imag);
    end else if (is_f32) begin
      fexp_max     = &f32[30:23];
      fexp_zero    = ~|f32[30:23];
      frac_nz      = |f32[22:0];
      ctl_next.neg = f32[31];
      mant_next    = asn_pkg::MANT_W'({~fexp_zero, f32[22:0]});
      rs_full      = fexp_zero ? asn_pkg::F32_BIAS - 13'sd1
                               : asn_pkg::F32_BIAS - $signed({5'b0, f32[30:23]});
    end else if (is_f64) begin
      fexp_max     = &f64[62:52];
      fexp_zero    = ~|f64[62:52];
      frac_nz      = |f64[51:0];
      ctl_next.neg = f64[63];
      mant_next    = asn_pkg::MANT_W'({~fexp_zero, f64[51:0]});
      rs_full      = fexp_zero ? asn_pkg::F64_BIAS - 13'sd1
                               : asn_pkg::F64_BIAS - $signed({2'b0, f64[62:52]});
    end else begin
      ctl_next.zero   = 1'b1;
      ctl_next.status = asn_pkg::ST_UNSUPPORTED;
    end

    // all-ones exponent: nan or infinity
    if (fexp_max) begin
      if (frac_nz) begin
        ctl_next.zero   = 1'b1;
        ctl_next.status = asn_pkg::ST_NAN;
      end else begin
        ctl_next.sat = 1'b1;
      end
    end

    // negative shift means a magnitude far above 1.0
    if (rs_full < 0) begin
      ctl_next.sat = 1'b1;
    end

    if (rs_full < 0) begin
      rshift_next = '0;
    end else if (rs_full > RS_MAX) begin
      rshift_next = '1;
    end else begin
      rshift_next = rs_full[asn_pkg::RS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
    mant   <= mant_next;
    rshift <= rshift_next;
  end

endmodule

>>> design/asn_shift.sv
module asn_shift (
  input  logic                          clk,
  input  logic                          rst,
  input  asn_pkg::ctl_t                 ctl_in,
  input  logic [asn_pkg::MANT_W-1:0]    mant,
  input  logic [asn_pkg::RS_W-1:0]      rshift,
  output asn_pkg::ctl_t                 ctl,
  output logic [asn_pkg::WIN_W-1:0]     quot,
  output logic                          guard,
  output logic                          sticky
);

  localparam int EXT_W = 2 * asn_pkg::WIN_W;

  logic [EXT_W-1:0] ext;

  // window is mant * 2^FRAC_BITS; the lower half catches the shifted-out bits
  assign ext = {mant, {asn_pkg::FRAC_BITS{1'b0}}, {asn_pkg::WIN_W{1'b0}}} >> rshift;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
    quot   <= ext[EXT_W-1:asn_pkg::WIN_W];
    guard  <= ext[asn_pkg::WIN_W-1];
    sticky <= |ext[asn_pkg::WIN_W-2:0];
  end

endmodule

>>> design/asn_round.sv
module asn_round (
  input  logic                                clk,
  input  logic                                rst,
  input  asn_pkg::ctl_t                       ctl_in,
  input  logic [asn_pkg::WIN_W-1:0]           quot,
  input  logic                                guard,
  input  logic                                sticky,
  output logic                                done,
  output logic signed [asn_pkg::VALUE_W-1:0]  sample_value,
  output logic [1:0]                          status
);

  localparam int MAG_W = asn_pkg::FRAC_BITS + 2;
  localparam logic [MAG_W-1:0] LIM = {2'b01, {asn_pkg::FRAC_BITS{1'b0}}};

  logic                                hi_over;
  logic                                inc;
  logic [MAG_W-1:0]                    rounded;
  logic [MAG_W-1:0]                    mag;
  logic [asn_pkg::VALUE_W-1:0]         umag;
  logic signed [asn_pkg::VALUE_W-1:0]  value_next;

  always_comb begin
    hi_over = |quot[asn_pkg::WIN_W-1:asn_pkg::FRAC_BITS+1];
    // round half to even
    inc     = guard & (sticky | quot[0]);
    rounded = {1'b0, quot[asn_pkg::FRAC_BITS:0]} + MAG_W'(inc);

    if (ctl_in.zero) begin
      mag = '0;
    end else if (ctl_in.sat || hi_over || rounded > LIM) begin
      mag = LIM;
    end else begin
      mag = rounded;
    end

    umag       = asn_pkg::VALUE_W'(mag);
    value_next = ctl_in.neg ? $signed(-umag) : $signed(umag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    sample_value <= value_next;
    status       <= ctl_in.status;
  end

endmodule

>>> design/aiff_sample_normalizer.sv
// channel   direction  ports                                   handshake
// -------   ---------  -----                                   ---------
// sample    in         sample_bytes                            start & !busy
// result    out        sample_value, status                    done, one cycle
// config    in         cfg_index, cfg_data                     cfg_we
//
// one word enters per cycle; decode, shift and round each register it in turn
// and done rises with the registered result; the rate is one word per clock
// busy never rises: every stage moves each cycle and the receiver cannot stall
// rst clears the stage valid bits and restores encoding and sample_bits
module aiff_sample_normalizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [63:0]                         sample_bytes,
  output logic                                done,
  output logic signed [asn_pkg::VALUE_W-1:0]  sample_value,
  output logic [1:0]                          status,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [6:0]                          cfg_data
);

  // configuration registers
  asn_pkg::enc_t                    encoding;
  logic [6:0]                       sample_bits;

  // decode -> shift
  asn_pkg::ctl_t                    dec_ctl;
  logic [asn_pkg::MANT_W-1:0]       dec_mant;
  logic [asn_pkg::RS_W-1:0]         dec_rshift;

  // shift -> round
  asn_pkg::ctl_t                    shf_ctl;
  logic [asn_pkg::WIN_W-1:0]        shf_quot;
  logic                             shf_guard;
  logic                             shf_sticky;

  // the pipeline never holds a word back
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding    <= asn_pkg::ENCODING_RESET;
      sample_bits <= asn_pkg::SAMPLE_BITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asn_pkg::CFG_ENCODING:    encoding    <= asn_pkg::enc_t'(cfg_data[1:0]);
        asn_pkg::CFG_SAMPLE_BITS: sample_bits <= cfg_data;
        default:                  sample_bits <= sample_bits;
      endcase
    end
  end

  // stage 1: pick the format, gather bytes, split sign / significand / shift
  asn_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .start        (start & ~busy),
    .sample_bytes (sample_bytes),
    .encoding     (encoding),
    .sample_bits  (sample_bits),
    .ctl          (dec_ctl),
    .mant         (dec_mant),
    .rshift       (dec_rshift)
  );

  // stage 2: align the significand to the fixed-point grid, keep guard and sticky
  asn_shift u_shift (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (dec_ctl),
    .mant   (dec_mant),
    .rshift (dec_rshift),
    .ctl    (shf_ctl),
    .quot   (shf_quot),
    .guard  (shf_guard),
    .sticky (shf_sticky)
  );

  // stage 3: round to nearest even, clamp to +-1.0, apply sign
  asn_round u_round (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (shf_ctl),
    .quot         (shf_quot),
    .guard        (shf_guard),
    .sticky       (shf_sticky),
    .done         (done),
    .sample_value (sample_value),
    .status       (status)
  );

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // decode, shift and round stages between acceptance and the result strobe
  localparam int PIPE_DEPTH  = 3;
  // far above the slowest run: 727 words, sender pauses, drains
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASES      = 14;
  localparam int PHASE_WORDS = 50;

  // one normalized sample as the block should report it
  typedef struct {
    logic [asn_pkg::VALUE_W-1:0] value;
    asn_pkg::status_t            st;
  } norm_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [63:0]        sample_bytes = '0;
  logic               done;
  logic signed [asn_pkg::VALUE_W-1:0] sample_value;
  logic [1:0]         status;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [6:0]         cfg_data = '0;

  // shadow of the format registers, starts at the reset values
  asn_pkg::enc_t cur_encoding = asn_pkg::ENCODING_RESET;
  logic [6:0]    cur_bits = asn_pkg::SAMPLE_BITS_RESET;

  // normalized samples still owed by the block, oldest first
  norm_word_t normalized_fifo[$];
  int         fail_count = 0;
  int         cycle_count = 0;

  aiff_sample_normalizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_bytes (sample_bytes),
    .done         (done),
    .sample_value (sample_value),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // normalizer model
  // ---------------------------------------------------------------------------

  // first file byte is the most significant
  function automatic logic [63:0] read_be(input logic [63:0] raw, input int n);
    logic [63:0] acc;
    acc = '0;
    for (int k = 0; k < n; k++) acc = (acc << 8) | raw[8*k +: 8];
    return acc;
  endfunction

  // magnitude of m * 2^(e + FRAC_BITS), round half to even, clamp at 1.0
  function automatic logic [63:0] scale_mag(input logic [63:0] m, input int e);
    logic [63:0] lim, q, rem, half;
    int s;
    int r;
    lim = 64'd1 << asn_pkg::FRAC_BITS;
    s = e + asn_pkg::FRAC_BITS;
    if (m == 0) return '0;
    if (s >= 0) begin
      if (s > asn_pkg::FRAC_BITS || m > (lim >> s)) return lim;
      return m << s;
    end
    if (s < -60) return '0;
    r = -s;
    q = m >> r;
    rem = m & ((64'd1 << r) - 64'd1);
    half = 64'd1 << (r - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return (q > lim) ? lim : q;
  endfunction

  function automatic logic [asn_pkg::VALUE_W-1:0] apply_sign(input logic neg,
                                                             input logic [63:0] mag);
    logic [asn_pkg::VALUE_W-1:0] v;
    v = mag[asn_pkg::VALUE_W-1:0];
    return neg ? -v : v;
  endfunction

  // signed n-bit pcm, 2^(n-1) is full scale
  function automatic logic [asn_pkg::VALUE_W-1:0] pcm_fix(input logic [63:0] v, input int n);
    logic [63:0] sign_bit, mask, mag;
    logic neg;
    sign_bit = 64'd1 << (n - 1);
    mask = (sign_bit << 1) - 64'd1;
    v = v & mask;
    neg = (v & sign_bit) != 0;
    mag = neg ? ((-v) & mask) : v;
    return apply_sign(neg, scale_mag(mag, -(n - 1)));
  endfunction

  // ieee binary float of any exponent and fraction width
  function automatic logic [asn_pkg::VALUE_W-1:0] float_fix(input logic [63:0] bits,
                                                            input int ebits,
                                                            input int fbits,
                                                            output asn_pkg::status_t st);
    logic [63:0] frac, emax, ex, m;
    logic neg;
    int bias;
    int e;
    st = asn_pkg::ST_OK;
    frac = bits & ((64'd1 << fbits) - 64'd1);
    emax = (64'd1 << ebits) - 64'd1;
    ex = (bits >> fbits) & emax;
    neg = bits[fbits + ebits];
    bias = int'(emax >> 1) + fbits;
    if (ex == emax) begin
      if (frac != 0) begin
        st = asn_pkg::ST_NAN;
        return '0;
      end
      // infinity saturates
      return apply_sign(neg, 64'd1 << asn_pkg::FRAC_BITS);
    end
    if (ex == 0) begin
      m = frac;
      e = 1 - bias;
    end else begin
      m = frac | (64'd1 << fbits);
      e = int'(ex) - bias;
    end
    return apply_sign(neg, scale_mag(m, e));
  endfunction

  function automatic norm_word_t normalize_sample(input logic [63:0] raw);
    norm_word_t       w;
    asn_pkg::status_t fst;
    int               n;
    w.value = '0;
    w.st = asn_pkg::ST_OK;
    n = int'(cur_bits);
    if (cur_encoding == asn_pkg::ENC_PCM_BE && (n == 8 || n == 16 || n == 24 || n == 32)) begin
      w.value = pcm_fix(read_be(raw, n / 8), n);
    end else if (cur_encoding == asn_pkg::ENC_PCM_LE && n == 16) begin
      w.value = pcm_fix({48'd0, raw[15:0]}, 16);
    end else if (cur_encoding == asn_pkg::ENC_FLOAT32 && n == 32) begin
      w.value = float_fix(read_be(raw, 4), 8, 23, fst);
      w.st = fst;
    end else if (cur_encoding == asn_pkg::ENC_FLOAT64 && n == 64) begin
      w.value = float_fix(read_be(raw, 8), 11, 52, fst);
      w.st = fst;
    end else begin
      w.st = asn_pkg::ST_UNSUPPORTED;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // lays out an n-byte big-endian value in file order, junk in the unused bytes
  function automatic logic [63:0] be_pack(input logic [63:0] v, input int n);
    logic [63:0] res;
    res = {$urandom, $urandom};
    for (int k = 0; k < n; k++) res[8*k +: 8] = v[8*(n-1-k) +: 8];
    return res;
  endfunction

  // float bit pattern biased toward the (-4, 4) range plus zeros, denormals,
  // infinities and nans
  function automatic logic [63:0] rand_float(input bit dbl);
    logic [63:0] frac, ex, emax, bias;
    logic sign;
    int ebits;
    int fbits;
    ebits = dbl ? 11 : 8;
    fbits = dbl ? 52 : 23;
    emax = (64'd1 << ebits) - 64'd1;
    bias = emax >> 1;
    sign = $urandom_range(0, 1);
    frac = {$urandom, $urandom} & ((64'd1 << fbits) - 64'd1);
    // cleared low fraction bits make exact rounding ties likely
    if ($urandom_range(0, 3) == 0)
      frac = frac & ~((64'd1 << $urandom_range(0, fbits)) - 64'd1);
    case ($urandom_range(0, 9))
      0: ex = '0;
      1: ex = emax;
      2: ex = {$urandom, $urandom} & emax;
      default: ex = bias + 64'd1 - 64'($urandom_range(0, 40));
    endcase
    return (64'(sign) << (ebits + fbits)) | (ex << fbits) | frac;
  endfunction

  function automatic logic [63:0] random_sample();
    if (cur_encoding == asn_pkg::ENC_FLOAT32 && cur_bits == 7'd32)
      return be_pack(rand_float(1'b0), 4);
    if (cur_encoding == asn_pkg::ENC_FLOAT64 && cur_bits == 7'd64)
      return be_pack(rand_float(1'b1), 8);
    return {$urandom, $urandom};
  endfunction

  // start stays high when the next word follows at once
  task automatic send_word(input logic [63:0] bytes);
    start <= 1'b1;
    sample_bytes <= bytes;
    do @(posedge clk); while (busy);
    normalized_fifo.push_back(normalize_sample(bytes));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // every word yields a result, so an empty fifo means the pipe is empty
  task automatic drain_results();
    start <= 1'b0;
    while (normalized_fifo.size() != 0) @(posedge clk);
  endtask

  // both registers, back to back; junk above the two encoding bits
  task automatic set_format(input asn_pkg::enc_t enc, input logic [6:0] bits);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= asn_pkg::CFG_ENCODING;
    cfg_data <= {5'($urandom), enc};
    @(posedge clk);
    cur_encoding = enc;
    cfg_index <= asn_pkg::CFG_SAMPLE_BITS;
    cfg_data <= bits;
    @(posedge clk);
    cur_bits = bits;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: the strobe lasts one cycle and cannot be held off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    norm_word_t want;
    if (!rst && done) begin
      if (normalized_fifo.size() == 0) begin
        $display("%0t: unexpected word value=%h status=%0d", $time, sample_value, status);
        fail_count++;
      end else begin
        want = normalized_fifo.pop_front();
        if (sample_value !== want.value) begin
          $display("%0t: sample_value expected %h actual %h", $time, want.value, sample_value);
          fail_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // no register write yet: 16-bit big-endian pcm out of reset
  task automatic test_reset_defaults();
    send_word(be_pack(64'h7FFF, 2));
    send_word(be_pack(64'h8000, 2));
  endtask

  // full scale and most negative code at 8 and 32 bits, the most negative code at 24
  task automatic test_pcm_widths();
    set_format(asn_pkg::ENC_PCM_BE, 7'd8);
    send_word(be_pack(64'h7F, 1));
    send_word(be_pack(64'h80, 1));
    set_format(asn_pkg::ENC_PCM_BE, 7'd24);
    send_word(be_pack(64'h800000, 3));
    set_format(asn_pkg::ENC_PCM_BE, 7'd32);
    send_word(be_pack(64'h7FFFFFFF, 4));
    send_word(be_pack(64'h80000000, 4));
  endtask

  // little-endian 16 bit: low byte comes first in the file
  task automatic test_sowt();
    set_format(asn_pkg::ENC_PCM_LE, 7'd16);
    send_word(be_pack(64'hFF7F, 2));
    send_word(be_pack(64'h0080, 2));
  endtask

  task automatic test_float32_cases();
    set_format(asn_pkg::ENC_FLOAT32, 7'd32);
    send_word(be_pack(64'h3F800000, 4));  // +1.0
    send_word(be_pack(64'hBF800000, 4));  // -1.0
    send_word(be_pack(64'h7F800000, 4));  // +inf saturates
    send_word(be_pack(64'hFF800000, 4));  // -inf saturates
    send_word(be_pack(64'h7FC00001, 4));  // nan
    send_word(be_pack(64'h40000000, 4));  // 2.0 clamps
    send_word(be_pack(64'h80000000, 4));  // negative zero
    send_word(be_pack(64'h00000001, 4));  // smallest denormal
    send_word(be_pack(64'h30400000, 4));  // 1.5 lsb, tie rounds to even
  endtask

  task automatic test_float64_cases();
    set_format(asn_pkg::ENC_FLOAT64, 7'd64);
    send_word(be_pack(64'h3FF0000000000000, 8));  // +1.0
    send_word(be_pack(64'hBFE0000000000000, 8));  // -0.5
    send_word(be_pack(64'hFFF0000000000000, 8));  // -inf
    send_word(be_pack(64'h7FF8000000000001, 8));  // nan
    send_word(be_pack(64'h0000000000000001, 8));  // smallest denormal
  endtask

  // mismatched encoding and size, register extremes included
  task automatic test_unsupported_pairs();
    set_format(asn_pkg::ENC_PCM_BE, 7'd0);
    send_word({$urandom, $urandom});
    set_format(asn_pkg::ENC_PCM_LE, 7'd127);
    send_word({$urandom, $urandom});
    set_format(asn_pkg::ENC_FLOAT32, 7'd64);
    send_word({$urandom, $urandom});
    set_format(asn_pkg::ENC_FLOAT64, 7'd32);
    send_word({$urandom, $urandom});
  endtask

  // phases of random words, mostly in supported formats, bursty sender
  task automatic test_random_stream();
    asn_pkg::enc_t pair_enc[7] = '{asn_pkg::ENC_PCM_BE, asn_pkg::ENC_PCM_BE,
                                   asn_pkg::ENC_PCM_BE, asn_pkg::ENC_PCM_BE,
                                   asn_pkg::ENC_PCM_LE, asn_pkg::ENC_FLOAT32,
                                   asn_pkg::ENC_FLOAT64};
    logic [6:0]    pair_bits[7] = '{7'd8, 7'd16, 7'd24, 7'd32, 7'd16, 7'd32, 7'd64};
    int            sel;
    int            burst;
    bit            steady;
    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(0, 9) < 8) begin
        sel = $urandom_range(0, 6);
        set_format(pair_enc[sel], pair_bits[sel]);
      end else begin
        set_format(asn_pkg::enc_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
      end
      // some phases run back to back with no gaps at all
      steady = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(1, 12);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word(random_sample());
        if (!steady) begin
          burst--;
          if (burst == 0) begin
            pause_sender($urandom_range(1, 6));
            burst = $urandom_range(1, 12);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_pcm_widths();
    test_sowt();
    test_float32_cases();
    test_float64_cases();
    test_unsupported_pairs();
    test_random_stream();
    drain_results();
    // watch for stray strobes after the last word
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
design/asn_pkg.sv
design/asn_decode.sv
design/asn_shift.sv
design/asn_round.sv
design/aiff_sample_normalizer.sv
verif/testbench.sv
